// ===== rtl/fpda_pkg.sv =====
`default_nettype none
package fpda_pkg;

	localparam int unsigned OP_W   = 2;
	localparam int unsigned WORD_W = 32;
	localparam int unsigned CODE_W = 10;

	localparam logic [OP_W-1:0] OP_SEED  = 2'd0;
	localparam logic [OP_W-1:0] OP_NNORM = 2'd1;
	localparam logic [OP_W-1:0] OP_ADJ   = 2'd2;

	localparam logic [WORD_W-1:0] ONE_BITS  = 32'h3f80_0000;
	localparam logic [7:0]        EXP_ODD   = 8'd127;
	localparam logic [7:0]        EXP_EVEN  = 8'd128;
	localparam logic [7:0]        EXP_BIAS  = 8'd127;
	localparam logic [7:0]        SEED_EXP  = 8'h7d;
	localparam logic [8:0]        SPEC_BASE = 9'h180;

	// Per-operand classification, normalized value and exponent code.
	typedef struct packed {
		logic                is_inf;
		logic                is_nan;
		logic                is_zero;
		logic [WORD_W-1:0]   norm;
		logic [CODE_W-1:0]   code;
	} opnd_t;

	localparam logic [7:0] SEED_ROM [128] = '{
		8'd255, 8'd253, 8'd251, 8'd249, 8'd247, 8'd245, 8'd244, 8'd242,
		8'd240, 8'd238, 8'd237, 8'd235, 8'd233, 8'd232, 8'd230, 8'd228,
		8'd227, 8'd225, 8'd224, 8'd222, 8'd221, 8'd219, 8'd218, 8'd216,
		8'd215, 8'd213, 8'd212, 8'd211, 8'd209, 8'd208, 8'd207, 8'd205,
		8'd204, 8'd203, 8'd202, 8'd200, 8'd199, 8'd198, 8'd197, 8'd196,
		8'd194, 8'd193, 8'd192, 8'd191, 8'd190, 8'd189, 8'd188, 8'd187,
		8'd186, 8'd185, 8'd184, 8'd183, 8'd182, 8'd181, 8'd180, 8'd179,
		8'd178, 8'd177, 8'd176, 8'd175, 8'd174, 8'd173, 8'd172, 8'd171,
		8'd170, 8'd169, 8'd168, 8'd168, 8'd167, 8'd166, 8'd165, 8'd164,
		8'd163, 8'd163, 8'd162, 8'd161, 8'd160, 8'd159, 8'd159, 8'd158,
		8'd157, 8'd156, 8'd156, 8'd155, 8'd154, 8'd153, 8'd153, 8'd152,
		8'd151, 8'd151, 8'd150, 8'd149, 8'd149, 8'd148, 8'd147, 8'd147,
		8'd146, 8'd145, 8'd145, 8'd144, 8'd143, 8'd143, 8'd142, 8'd142,
		8'd141, 8'd140, 8'd140, 8'd139, 8'd139, 8'd138, 8'd137, 8'd137,
		8'd136, 8'd136, 8'd135, 8'd135, 8'd134, 8'd133, 8'd133, 8'd132,
		8'd132, 8'd131, 8'd131, 8'd130, 8'd130, 8'd129, 8'd129, 8'd129
	};

endpackage
`default_nettype wire

// ===== rtl/fpda_operand.sv =====
`default_nettype none
module fpda_operand (
	input  wire logic [fpda_pkg::WORD_W-1:0] x,
	output fpda_pkg::opnd_t                  info
);

	logic [7:0]  exp_f;
	logic [22:0] mant;
	logic        denorm;
	logic [4:0]  lz;
	logic [22:0] mant_sh;
	logic        parity;
	logic [9:0]  diff;

	assign exp_f  = x[30:23];
	assign mant   = x[22:0];
	assign denorm = (exp_f == 8'd0);

	// Leading zeros of the 23-bit mantissa; the highest set bit wins.
	always_comb begin
		lz = 5'd0;
		for (int i = 0; i < 23; i++) begin
			if (mant[i]) begin
				lz = 5'(22 - i);
			end
		end
	end

	// The leading one of a denormal is shifted out and dropped.
	assign mant_sh = mant << (lz + 5'd1);
	assign parity  = denorm ? lz[0] : exp_f[0];

	assign diff = denorm ? (10'd0 - {5'd0, lz} - {2'd0, fpda_pkg::EXP_BIAS})
	                     : ({2'd0, exp_f} - {2'd0, fpda_pkg::EXP_BIAS});

	always_comb begin
		info.is_inf  = (exp_f == 8'hff) && (mant == 23'd0);
		info.is_nan  = (exp_f == 8'hff) && (mant != 23'd0);
		info.is_zero = (x[30:0] == 31'd0);
		info.code    = {diff[9:1], 1'b0};
		if (info.is_inf || info.is_zero) begin
			info.norm = {x[31], fpda_pkg::ONE_BITS[30:0]};
		end else if (info.is_nan) begin
			info.norm = x;
		end else begin
			info.norm = {x[31], parity ? fpda_pkg::EXP_ODD : fpda_pkg::EXP_EVEN,
			             denorm ? mant_sh : mant};
		end
	end

endmodule
`default_nettype wire

// ===== rtl/fpda_core.sv =====
`default_nettype none
module fpda_core (
	input  wire logic [fpda_pkg::OP_W-1:0]   op,
	input  wire logic [fpda_pkg::WORD_W-1:0] a_bits,
	input  wire logic [fpda_pkg::WORD_W-1:0] b_bits,
	output logic      [fpda_pkg::WORD_W-1:0] result_bits
);

	fpda_pkg::opnd_t a_info;
	fpda_pkg::opnd_t b_info;

	logic [31:0] n;
	logic [31:0] seed_word;
	logic [31:0] adj_word;
	logic [7:0]  rom_val;
	logic        a_spec;
	logic        b_spec;
	logic        inf_f;
	logic        nan_f;
	logic        neg_f;
	logic [9:0]  r;
	logic [7:0]  hi;
	logic [7:0]  lo;

	fpda_operand u_opnd_a (.x(a_bits), .info(a_info));
	fpda_operand u_opnd_b (.x(b_bits), .info(b_info));

	assign n       = a_info.norm;
	assign rom_val = fpda_pkg::SEED_ROM[n[22:16]];

	// The seed exponent steps up by one when the normalized exponent is odd.
	assign seed_word = {n[31], fpda_pkg::SEED_EXP + {7'd0, n[23]}, rom_val[6:0], 16'd0};

	assign a_spec = a_info.is_inf || a_info.is_nan || a_info.is_zero;
	assign b_spec = b_info.is_inf || b_info.is_nan || b_info.is_zero;
	assign inf_f  = (a_info.is_inf && !(b_info.is_inf || b_info.is_nan)) ||
	                (!a_spec && b_info.is_zero);
	assign nan_f  = a_info.is_nan || b_info.is_nan ||
	                (a_info.is_zero && b_info.is_zero) ||
	                (a_info.is_inf && b_info.is_inf);
	assign neg_f  = a_bits[31] ^ b_bits[31];

	assign r  = (a_spec || b_spec)
	          ? {1'b0, fpda_pkg::SPEC_BASE | {6'd0, nan_f, inf_f, neg_f}}
	          : (a_info.code - b_info.code);
	assign hi = {r[9:5], 3'd0} + fpda_pkg::EXP_BIAS;
	assign lo = {r[4:0], 3'd0} + fpda_pkg::EXP_BIAS;
	assign adj_word = {1'b0, lo, 1'b0, hi, 14'd0};

	always_comb begin
		case (op)
			fpda_pkg::OP_SEED:  result_bits = seed_word;
			fpda_pkg::OP_NNORM: result_bits = n ^ 32'h8000_0000;
			fpda_pkg::OP_ADJ:   result_bits = adj_word;
			default:            result_bits = 32'd0;
		endcase
	end

endmodule
`default_nettype wire

// ===== rtl/fp_divide_assist_unit.sv =====
`default_nettype none
// Division-assist unit for binary32 operands. A word is taken at every clock edge where
// start is high; busy is never raised, so one word can be issued every cycle. The result
// appears on result_bits with done high for exactly one cycle, starting at the clock edge after
// the word was taken: the word sits in the input register while the operand classifiers,
// the seed table and the exponent subtract settle, and the result register catches the
// outcome at that edge. The receiver cannot stall the unit, so a result must be captured
// in the cycle done is high.
module fp_divide_assist_unit (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	output logic                               busy,
	input  wire logic [fpda_pkg::OP_W-1:0]     op,
	input  wire logic [fpda_pkg::WORD_W-1:0]   a_bits,
	input  wire logic [fpda_pkg::WORD_W-1:0]   b_bits,
	output logic                               done,
	output logic      [fpda_pkg::WORD_W-1:0]   result_bits
);

	logic                          valid_s1;
	logic [fpda_pkg::OP_W-1:0]     op_s1;
	logic [fpda_pkg::WORD_W-1:0]   a_s1;
	logic [fpda_pkg::WORD_W-1:0]   b_s1;
	logic [fpda_pkg::WORD_W-1:0]   res_c;
	logic                          done_s2;
	logic [fpda_pkg::WORD_W-1:0]   result_s2;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			done_s2  <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
			done_s2  <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			op_s1 <= op;
			a_s1  <= a_bits;
			b_s1  <= b_bits;
		end
		if (valid_s1) begin
			result_s2 <= res_c;
		end
	end

	fpda_core u_core (
		.op          (op_s1),
		.a_bits      (a_s1),
		.b_bits      (b_s1),
		.result_bits (res_c)
	);

	assign done        = done_s2;
	assign result_bits = result_s2;

	a_start_done: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> ##1 done)
		else $error("accepted word did not produce a result two cycles later");

	a_done_origin: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(valid_s1))
		else $error("result strobe without a word in the input register");

	a_unused_zero: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && (op_s1 != fpda_pkg::OP_SEED) && (op_s1 != fpda_pkg::OP_NNORM) &&
		(op_s1 != fpda_pkg::OP_ADJ) |=> result_bits == 32'd0)
		else $error("unused operation gave a nonzero result");

	a_adj_fields: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && (op_s1 == fpda_pkg::OP_ADJ) |=>
		(result_bits[31] == 1'b0) && (result_bits[22] == 1'b0) &&
		(result_bits[13:0] == 14'd0))
		else $error("exponent adjust result has bits outside its fields");

	a_seed_low: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && (op_s1 == fpda_pkg::OP_SEED) |=> result_bits[15:0] == 16'd0)
		else $error("reciprocal seed has nonzero low mantissa bits");

endmodule
`default_nettype wire

// ===== test/tb_fp_divide_assist_unit.sv =====
`timescale 1ns / 100ps

module tb_fp_divide_assist_unit;

	localparam logic [fpda_pkg::OP_W-1:0] OP_NONE = 2'd3;

	localparam logic [31:0] SIGN_BIT   = 32'h8000_0000;
	localparam logic [31:0] UNIT_BITS  = 32'h3f80_0000;
	localparam logic [31:0] SEED_BASE  = 32'h3e80_0000;
	localparam logic [31:0] MANT_MASK  = 32'h007f_ffff;
	localparam logic [31:0] PAIR_CODE  = 32'h0000_0180;
	localparam logic [30:0] INF_MAG    = 31'h7f80_0000;

	localparam int RANDOM_PER_PHASE = 434;
	localparam int RUN_LIMIT_NS     = 200_000;

	localparam logic [7:0] SEED_TABLE [128] = '{
		8'd255, 8'd253, 8'd251, 8'd249, 8'd247, 8'd245, 8'd244, 8'd242,
		8'd240, 8'd238, 8'd237, 8'd235, 8'd233, 8'd232, 8'd230, 8'd228,
		8'd227, 8'd225, 8'd224, 8'd222, 8'd221, 8'd219, 8'd218, 8'd216,
		8'd215, 8'd213, 8'd212, 8'd211, 8'd209, 8'd208, 8'd207, 8'd205,
		8'd204, 8'd203, 8'd202, 8'd200, 8'd199, 8'd198, 8'd197, 8'd196,
		8'd194, 8'd193, 8'd192, 8'd191, 8'd190, 8'd189, 8'd188, 8'd187,
		8'd186, 8'd185, 8'd184, 8'd183, 8'd182, 8'd181, 8'd180, 8'd179,
		8'd178, 8'd177, 8'd176, 8'd175, 8'd174, 8'd173, 8'd172, 8'd171,
		8'd170, 8'd169, 8'd168, 8'd168, 8'd167, 8'd166, 8'd165, 8'd164,
		8'd163, 8'd163, 8'd162, 8'd161, 8'd160, 8'd159, 8'd159, 8'd158,
		8'd157, 8'd156, 8'd156, 8'd155, 8'd154, 8'd153, 8'd153, 8'd152,
		8'd151, 8'd151, 8'd150, 8'd149, 8'd149, 8'd148, 8'd147, 8'd147,
		8'd146, 8'd145, 8'd145, 8'd144, 8'd143, 8'd143, 8'd142, 8'd142,
		8'd141, 8'd140, 8'd140, 8'd139, 8'd139, 8'd138, 8'd137, 8'd137,
		8'd136, 8'd136, 8'd135, 8'd135, 8'd134, 8'd133, 8'd133, 8'd132,
		8'd132, 8'd131, 8'd131, 8'd130, 8'd130, 8'd129, 8'd129, 8'd129
	};

	typedef struct packed {
		logic [fpda_pkg::OP_W-1:0] op;
		logic [31:0]               a;
		logic [31:0]               b;
		logic                      pin;
		logic [31:0]               want;
	} stim_row_t;

	localparam int N_ROWS = 25;

	// Rows with pin set carry a hand-worked result; the others go through the predictor.
	localparam stim_row_t DIRECTED_ROWS [N_ROWS] = '{
		'{fpda_pkg::OP_SEED,  32'h0000_0000, 32'h0000_0000, 1'b1, 32'h3f7f_0000},
		'{fpda_pkg::OP_SEED,  32'h8000_0000, 32'hffff_ffff, 1'b1, 32'hbf7f_0000},
		'{fpda_pkg::OP_NNORM, 32'h0000_0000, 32'h0000_0000, 1'b1, 32'hbf80_0000},
		'{fpda_pkg::OP_NNORM, 32'hff80_0000, 32'hffff_ffff, 1'b1, 32'h3f80_0000},
		'{fpda_pkg::OP_NNORM, 32'h7fc0_0001, 32'h0000_0000, 1'b1, 32'hffc0_0001},
		'{fpda_pkg::OP_NNORM, 32'hffff_ffff, 32'hffff_ffff, 1'b1, 32'h7fff_ffff},
		'{OP_NONE,            32'hffff_ffff, 32'hffff_ffff, 1'b1, 32'h0000_0000},
		'{OP_NONE,            32'h0000_0000, 32'h0000_0000, 1'b1, 32'h0000_0000},
		'{fpda_pkg::OP_ADJ,   32'h0000_0000, 32'h0000_0000, 1'b1, 32'h4fb7_c000},
		'{fpda_pkg::OP_ADJ,   32'h3f80_0000, 32'h0000_0000, 1'b1, 32'h47b7_c000},
		'{fpda_pkg::OP_ADJ,   32'h7f80_0000, 32'hbf80_0000, 1'b1, 32'h4bb7_c000},
		'{fpda_pkg::OP_ADJ,   32'h3f80_0000, 32'h3f80_0000, 1'b1, 32'h3f9f_c000},
		'{fpda_pkg::OP_ADJ,   32'h7f7f_ffff, 32'h0000_0001, 1'b0, 32'h0},
		'{fpda_pkg::OP_ADJ,   32'h0000_0001, 32'h7f7f_ffff, 1'b0, 32'h0},
		'{fpda_pkg::OP_ADJ,   32'hff80_0000, 32'h7f80_0000, 1'b0, 32'h0},
		'{fpda_pkg::OP_ADJ,   32'h3f80_0000, 32'h7fc0_0000, 1'b0, 32'h0},
		'{fpda_pkg::OP_ADJ,   32'h8000_0000, 32'h4049_0fdb, 1'b0, 32'h0},
		'{fpda_pkg::OP_SEED,  32'h0000_0001, 32'h0000_0000, 1'b0, 32'h0},
		'{fpda_pkg::OP_SEED,  32'h007f_ffff, 32'hffff_ffff, 1'b0, 32'h0},
		'{fpda_pkg::OP_SEED,  32'hff7f_ffff, 32'h0000_0000, 1'b0, 32'h0},
		'{fpda_pkg::OP_NNORM, 32'h0040_0000, 32'h0000_0000, 1'b0, 32'h0},
		'{fpda_pkg::OP_NNORM, 32'h8000_0001, 32'hffff_ffff, 1'b0, 32'h0},
		'{fpda_pkg::OP_NNORM, 32'h0080_0000, 32'h0000_0000, 1'b0, 32'h0},
		'{fpda_pkg::OP_NNORM, 32'h0100_0000, 32'h0000_0000, 1'b0, 32'h0},
		'{fpda_pkg::OP_SEED,  32'h7fff_ffff, 32'hffff_ffff, 1'b0, 32'h0}
	};

	logic                              clk = 1'b0;
	logic                              arst_n = 1'b0;
	logic                              start = 1'b0;
	logic [fpda_pkg::OP_W-1:0]         op = '0;
	logic [fpda_pkg::WORD_W-1:0]       a_bits = '0;
	logic [fpda_pkg::WORD_W-1:0]       b_bits = '0;
	logic                              busy;
	logic                              done;
	logic [fpda_pkg::WORD_W-1:0]       result_bits;

	logic                              pinned = 1'b0;
	logic [31:0]                       pinned_word = '0;
	logic [31:0]                       pending_results [$];
	logic [31:0]                       head_word;
	int                                mismatches = 0;
	int                                sender_idle_pct = 0;

	fp_divide_assist_unit uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.op(op),
		.a_bits(a_bits),
		.b_bits(b_bits),
		.done(done),
		.result_bits(result_bits)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic logic [31:0] lead_zeros32(input logic [31:0] v);
		logic [31:0] n;
		n = 32;
		for (int i = 0; i < 32; i++)
			if (v[i])
				n = 31 - i;
		return n;
	endfunction

	function automatic logic is_inf(input logic [31:0] x);
		return x[30:0] == INF_MAG;
	endfunction

	function automatic logic is_nan(input logic [31:0] x);
		return x[30:0] > INF_MAG;
	endfunction

	function automatic logic is_zero(input logic [31:0] x);
		return x[30:0] == 31'd0;
	endfunction

	function automatic logic [31:0] normalized_word(input logic [31:0] x);
		logic [31:0] e;
		logic [31:0] m;
		logic [31:0] d;
		if (is_inf(x) || is_zero(x))
			return (x & SIGN_BIT) | UNIT_BITS;
		if (is_nan(x))
			return x;
		e = {24'd0, x[30:23]};
		m = x & MANT_MASK;
		if (e == 0) begin
			// A denormal is shifted until its leading one drops out of the field.
			d = lead_zeros32(m) - 32'd8;
			m = (m << d) & MANT_MASK;
			e = 32'd1 - d;
		end
		return (x & SIGN_BIT) | ((32'd128 - (e & 32'd1)) << 23) | m;
	endfunction

	function automatic logic [31:0] exponent_code(input logic [31:0] x);
		logic [31:0] e;
		e = {24'd0, x[30:23]};
		if (e == 0)
			e = 32'd9 - lead_zeros32(x & MANT_MASK);
		return (e - 32'd127) & ~32'd1;
	endfunction

	function automatic logic [31:0] divide_assist_result(input logic [fpda_pkg::OP_W-1:0] w_op,
			input logic [31:0] a, input logic [31:0] b);
		logic [31:0] n;
		logic [31:0] r;
		logic [31:0] hi;
		logic [31:0] lo;
		logic        a_special;
		logic        b_special;
		logic        inf_flag;
		logic        nan_flag;
		case (w_op)
			fpda_pkg::OP_SEED: begin
				n = normalized_word(a);
				return (n & SIGN_BIT) | (SEED_BASE + (n & 32'h0080_0000))
					| ({25'd0, SEED_TABLE[n[22:16]][6:0]} << 16);
			end
			fpda_pkg::OP_NNORM: begin
				return normalized_word(a) ^ SIGN_BIT;
			end
			fpda_pkg::OP_ADJ: begin
				a_special = is_inf(a) || is_nan(a) || is_zero(a);
				b_special = is_inf(b) || is_nan(b) || is_zero(b);
				if (a_special || b_special) begin
					inf_flag = (is_inf(a) && !(is_inf(b) || is_nan(b))) || (!a_special && is_zero(b));
					nan_flag = is_nan(a) || is_nan(b) || (is_zero(a) && is_zero(b))
						|| (is_inf(a) && is_inf(b));
					r = PAIR_CODE | {29'd0, nan_flag, inf_flag, a[31] ^ b[31]};
				end else begin
					r = exponent_code(a) - exponent_code(b);
				end
				hi = (((r & 32'h3e0) >> 2) + 32'd127) & 32'hff;
				lo = (((r & 32'h01f) << 3) + 32'd127) & 32'hff;
				return (lo << 23) | (hi << 14);
			end
			default: begin
				return 32'd0;
			end
		endcase
	endfunction

	// Operands are biased toward specials and denormals so every normalize path is hit.
	function automatic logic [31:0] pick_operand();
		logic [31:0] w;
		w = $urandom();
		case ($urandom_range(7))
			0, 1: begin
			end
			2: begin
				case ($urandom_range(2))
					0: w[30:0] = 31'd0;
					1: w[30:0] = INF_MAG;
					default: w[30:0] = {8'hff, (w[22:0] == 23'd0) ? 23'd1 : w[22:0]};
				endcase
			end
			3, 4: begin
				w[30:23] = 8'd0;
				w[22:0] = w[22:0] >> $urandom_range(22);
				if (w[22:0] == 23'd0)
					w[0] = 1'b1;
			end
			default: begin
				w[30:23] = 8'($urandom_range(254, 1));
			end
		endcase
		return w;
	endfunction

	function automatic logic [fpda_pkg::OP_W-1:0] pick_op();
		int k;
		k = $urandom_range(19);
		if (k < 6)
			return fpda_pkg::OP_SEED;
		if (k < 12)
			return fpda_pkg::OP_NNORM;
		if (k < 19)
			return fpda_pkg::OP_ADJ;
		return OP_NONE;
	endfunction

	task automatic issue_word(input logic [fpda_pkg::OP_W-1:0] w_op, input logic [31:0] w_a,
			input logic [31:0] w_b, input logic w_pin, input logic [31:0] w_want);
		while ($urandom_range(99) < sender_idle_pct) begin
			start <= 1'b0;
			op <= 2'($urandom_range(3));
			a_bits <= $urandom();
			b_bits <= $urandom();
			@(posedge clk);
		end
		start <= 1'b1;
		op <= w_op;
		a_bits <= w_a;
		b_bits <= w_b;
		pinned <= w_pin;
		pinned_word <= w_want;
		@(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	always @(posedge clk) begin
		if (arst_n && done !== 1'b0) begin
			if (pending_results.size() == 0) begin
				$display("%0t: result_bits expected none got %h", $time, result_bits);
				mismatches++;
			end else begin
				head_word = pending_results.pop_front();
				if (result_bits !== head_word) begin
					$display("%0t: result_bits expected %h got %h", $time, head_word, result_bits);
					mismatches++;
				end
			end
		end
		if (arst_n && start && !busy)
			pending_results.push_back(pinned ? pinned_word : divide_assist_result(op, a_bits, b_bits));
	end

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		for (int i = 0; i < N_ROWS; i++)
			issue_word(DIRECTED_ROWS[i].op, DIRECTED_ROWS[i].a, DIRECTED_ROWS[i].b,
				DIRECTED_ROWS[i].pin, DIRECTED_ROWS[i].want);
		for (int phase = 0; phase < 3; phase++) begin
			sender_idle_pct = (phase == 0) ? 7 : (phase == 1) ? 79 : 0;
			for (int i = 0; i < RANDOM_PER_PHASE; i++)
				issue_word(pick_op(), pick_operand(), pick_operand(), 1'b0, 32'd0);
		end
		start <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		if (mismatches == 0)
			$display("fp_divide_assist_unit: match");
		else
			$display("fp_divide_assist_unit: mismatch");
		$finish;
	end

	initial begin
		#(RUN_LIMIT_NS);
		$display("fp_divide_assist_unit: mismatch");
		$finish;
	end

endmodule
